// ===== rtl/sync_length_deframer_with_echo_defines.svh =====
// assertion macros for the sync length deframer
// used by the top level only, clocked on clk_i and disabled while rst_ni is low
`ifndef SYNC_LENGTH_DEFRAMER_WITH_ECHO_DEFINES_SVH
`define SYNC_LENGTH_DEFRAMER_WITH_ECHO_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sld assertion failed");

// next-cycle implication
`define SLD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sld assertion failed");

`else

`define SLD_ASSERT_IMP(lbl, ante, cons)
`define SLD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/sld_pkg.sv =====
// shared constants and controller/datapath interface types of the deframer
// no dependencies
`timescale 1ns / 1ps

package sld_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 32;
  localparam logic [15:0] SYNC_WORD_RST   = 16'h776E;
  localparam logic [7:0]  ECHO_CMD        = 8'h09;

  typedef enum logic [1:0] {
    SEL_SYNC_LO = 2'd0,
    SEL_SYNC_HI = 2'd1,
    SEL_COUNT   = 2'd2,
    SEL_DATA    = 2'd3
  } out_sel_e;

  typedef struct packed {
    logic     set_len;
    logic     store_byte;
    logic     ld_count;
    logic     clr_idx;
    logic     rd_en;
    logic     ld_out;
    out_sel_e out_sel;
    logic     out_last;
    logic     inc_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic lo_match;
    logic hi_match;
    logic len_zero;
    logic frame_done;
    logic is_echo;
    logic out_free;
    logic idx_last;
  } dp_status_t;

endpackage

// ===== rtl/sld_ctrl.sv =====
// controller of the deframer: frame parsing phases and echo reply sequencing
// depends on sld_pkg
`timescale 1ns / 1ps

module sld_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  sld_pkg::dp_status_t status_i,
  output sld_pkg::dp_cmd_t    cmd_o
);
  import sld_pkg::*;

  typedef enum logic [8:0] {
    ST_HUNT_LO    = 9'b000000001,
    ST_WAIT_HI    = 9'b000000010,
    ST_WAIT_LEN   = 9'b000000100,
    ST_RECV       = 9'b000001000,
    ST_CHECK      = 9'b000010000,
    ST_TX_SYNC_LO = 9'b000100000,
    ST_TX_SYNC_HI = 9'b001000000,
    ST_TX_COUNT   = 9'b010000000,
    ST_TX_READ    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   tx_data_q, tx_data_d;  // second half of a data byte, after its read
  logic   rx_acc;

  assign rx_stall_o = !(state_q == ST_HUNT_LO || state_q == ST_WAIT_HI ||
                        state_q == ST_WAIT_LEN || state_q == ST_RECV);
  assign rx_acc = rx_valid_i && !rx_stall_o;

  always_comb begin
    state_d   = state_q;
    tx_data_d = 1'b0;
    cmd_o     = '0;
    case (state_q)
      ST_HUNT_LO: begin
        if (rx_acc && status_i.lo_match) state_d = ST_WAIT_HI;
      end
      ST_WAIT_HI: begin
        // any other byte keeps waiting here, low sync byte included
        if (rx_acc && status_i.hi_match) state_d = ST_WAIT_LEN;
      end
      ST_WAIT_LEN: begin
        if (rx_acc) begin
          cmd_o.set_len = 1'b1;
          state_d = status_i.len_zero ? ST_CHECK : ST_RECV;
        end
      end
      ST_RECV: begin
        if (rx_acc) begin
          cmd_o.store_byte = 1'b1;
          if (status_i.frame_done) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.ld_count = 1'b1;
        cmd_o.clr_idx  = 1'b1;
        state_d = status_i.is_echo ? ST_TX_SYNC_LO : ST_HUNT_LO;
      end
      ST_TX_SYNC_LO: begin
        if (status_i.out_free) begin
          cmd_o.ld_out  = 1'b1;
          cmd_o.out_sel = SEL_SYNC_LO;
          state_d = ST_TX_SYNC_HI;
        end
      end
      ST_TX_SYNC_HI: begin
        if (status_i.out_free) begin
          cmd_o.ld_out  = 1'b1;
          cmd_o.out_sel = SEL_SYNC_HI;
          state_d = ST_TX_COUNT;
        end
      end
      ST_TX_COUNT: begin
        if (status_i.out_free) begin
          cmd_o.ld_out  = 1'b1;
          cmd_o.out_sel = SEL_COUNT;
          state_d = ST_TX_READ;
        end
      end
      ST_TX_READ: begin
        if (!tx_data_q) begin
          // issue the store read, data is registered for the next cycle
          cmd_o.rd_en = 1'b1;
          tx_data_d = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.ld_out   = 1'b1;
          cmd_o.out_sel  = SEL_DATA;
          cmd_o.out_last = status_i.idx_last;
          cmd_o.inc_idx  = 1'b1;
          if (status_i.idx_last) state_d = ST_HUNT_LO;
        end else begin
          tx_data_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_HUNT_LO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HUNT_LO;
      tx_data_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tx_data_q <= tx_data_d;
    end
  end

endmodule

// ===== rtl/sld_dp.sv =====
// datapath of the deframer: sync register, counters, payload store, output register
// depends on sld_pkg, driven by sld_ctrl commands
`timescale 1ns / 1ps

module sld_dp #(
  parameter int unsigned STORE_DEPTH = sld_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                tx_stall_i,
  output logic                tx_valid_o,
  output logic [7:0]          tx_byte_o,
  output logic                tx_last_o,
  input  sld_pkg::dp_cmd_t    cmd_i,
  output sld_pkg::dp_status_t status_o
);
  import sld_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  logic [15:0]  sync_q;
  logic [7:0]   frame_len_q;
  logic [7:0]   rcv_cnt_q;
  logic [7:0]   rcv_cnt_inc;
  logic [7:0]   cmd0_q, cmd1_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q;
  logic [8:0]   count_sum;
  logic         wr_en;
  logic [AW-1:0] wr_addr;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] wr_seen_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;

  logic       tx_valid_q;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic       tx_last_q;

  assign cfg_ready_o = 1'b1;

  assign rcv_cnt_inc = rcv_cnt_q + 8'd1;
  assign wr_en   = cmd_i.store_byte && (rcv_cnt_q < 8'(STORE_DEPTH));
  assign wr_addr = rcv_cnt_q[AW-1:0];

  // echo count saturates at the store depth
  assign count_sum = {1'b0, cmd1_q} + 9'd2;
  assign count_d   = (count_sum > 9'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : CW'(count_sum);

  assign status_o.lo_match   = (rx_byte_i == sync_q[7:0]);
  assign status_o.hi_match   = (rx_byte_i == sync_q[15:8]);
  assign status_o.len_zero   = (rx_byte_i == 8'd0);
  assign status_o.frame_done = (rcv_cnt_inc >= frame_len_q);
  assign status_o.is_echo    = (cmd0_q == ECHO_CMD);
  assign status_o.out_free   = !tx_valid_q || !tx_stall_i;
  assign status_o.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= SYNC_WORD_RST;
      frame_len_q <= 8'd0;
      rcv_cnt_q   <= 8'd0;
      cmd0_q      <= 8'd0;
      cmd1_q      <= 8'd0;
      wr_seen_q   <= '0;
      count_q     <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) sync_q <= cfg_data_i;
      if (cmd_i.set_len) begin
        frame_len_q <= rx_byte_i;
        rcv_cnt_q   <= 8'd0;
      end else if (cmd_i.store_byte) begin
        rcv_cnt_q <= rcv_cnt_inc;
      end else if (cmd_i.ld_count) begin
        rcv_cnt_q <= 8'd0;
      end
      if (wr_en) begin
        wr_seen_q[wr_addr] <= 1'b1;
        // shadow copies of the command and length bytes
        if (rcv_cnt_q == 8'd0) cmd0_q <= rx_byte_i;
        if (rcv_cnt_q == 8'd1) cmd1_q <= rx_byte_i;
      end
      if (cmd_i.ld_count) count_q <= count_d;
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx && !status_o.idx_last) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= rx_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q  <= mem[idx_q];
      rvalid_q <= wr_seen_q[idx_q];
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      SEL_SYNC_LO: tx_byte_d = sync_q[7:0];
      SEL_SYNC_HI: tx_byte_d = sync_q[15:8];
      SEL_COUNT:   tx_byte_d = 8'(count_q);
      SEL_DATA:    tx_byte_d = rvalid_q ? rdata_q : 8'd0;
      default:     tx_byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid_q <= 1'b0;
    end else if (cmd_i.ld_out) begin
      tx_valid_q <= 1'b1;
    end else if (!tx_stall_i) begin
      tx_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      tx_byte_q <= tx_byte_d;
      tx_last_q <= cmd_i.out_last;
    end
  end

  assign tx_valid_o = tx_valid_q;
  assign tx_byte_o  = tx_byte_q;
  assign tx_last_o  = tx_last_q;

endmodule

// ===== rtl/sync_length_deframer_with_echo.sv =====
// top level of the sync length deframer with echo reply
// depends on sld_pkg, sld_ctrl, sld_dp and the assertion macro header
`timescale 1ns / 1ps
//
// rx channel: one received byte per item (rx_valid_i, rx_stall_o, rx_byte_i).
// the block hunts for sync_word low then high byte, takes a length byte and
// stores that many payload bytes; bytes past STORE_DEPTH are dropped.
// while parsing, one byte is taken per cycle.
// at frame end the command byte is checked in a separate check state with rx stalled.
// for the echo command a reply goes out on the tx channel (tx_valid_o,
// tx_stall_i, tx_byte_o, tx_last_o): sync low, sync high, count, then count
// store bytes, tx_last_o on the final one. count = min(payload[1] + 2, depth).
// the first reply byte is loaded after the command check state, from the sync low state;
// header bytes are loaded straight into the output register, data bytes take a store
// read, then an output register load, with the read data registered in between.
// rx stays stalled until the last reply byte is loaded.
// a stall on tx holds the output register and freezes the reply sequencer.
// cfg channel writes sync_word at any cycle (ready is always high).
// reset: sync_word 0x776E, hunting the low sync byte, store reads as zero
// through per-entry written flags, no clearing pass.
//

`include "sync_length_deframer_with_echo_defines.svh"

module sync_length_deframer_with_echo #(
  parameter int unsigned STORE_DEPTH = sld_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        tx_valid_o,
  input  logic        tx_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o
);
  import sld_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sld_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (rx_byte_i),
    .tx_stall_i  (tx_stall_i),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .tx_last_o   (tx_last_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // a stalled reply item stays valid and keeps its payload
  `SLD_ASSERT_NXT(a_tx_hold, tx_valid_o && tx_stall_i, tx_valid_o && $stable(tx_byte_o) && $stable(tx_last_o))
  // while rx is open the output register is empty or holds the final byte
  `SLD_ASSERT_IMP(a_parse_no_reply, !rx_stall_o, !tx_valid_o || tx_last_o)

endmodule

// ===== test/tb_sync_length_deframer_with_echo.sv =====
// testbench for sync_length_deframer_with_echo: directed frames, back-pressure and random traffic
// the block's received bytes are predicted in-line and the reply bytes checked in order
// depends on sld_pkg and the rtl of the block only
`timescale 1ns / 1ps

module tb_sync_length_deframer_with_echo;

  import sld_pkg::*;

  localparam int unsigned DEPTH          = STORE_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned PHASE_ITEMS    = 72;

  typedef enum logic [1:0] {
    HUNT_LO      = 2'd0,
    WAIT_HI      = 2'd1,
    WAIT_LEN     = 2'd2,
    RECV_PAYLOAD = 2'd3
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } tx_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;
  logic        rx_valid_i  = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        tx_valid_o;
  logic        tx_stall_i  = 1'b0;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;

  // predicted state of the deframer
  logic [15:0]  sync_word;
  parse_phase_e phase;
  logic [7:0]   frame_len;
  logic [7:0]   rcvd_cnt;
  logic [7:0]   store [DEPTH];

  tx_beat_t reply_q [$];
  tx_beat_t exp_beat;

  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_len     = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  bit          idle_en      = 1'b1;

  sync_length_deframer_with_echo #(
    .STORE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .tx_valid_o (tx_valid_o),
    .tx_stall_i (tx_stall_i),
    .tx_byte_o  (tx_byte_o),
    .tx_last_o  (tx_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  task automatic close_frame();
    int unsigned cnt;
    phase    = HUNT_LO;
    rcvd_cnt = '0;
    if (store[0] == ECHO_CMD) begin
      cnt = int'(store[1]) + 2;
      if (cnt > DEPTH) cnt = DEPTH;
      reply_q.push_back('{data: sync_word[7:0], is_last: 1'b0});
      reply_q.push_back('{data: sync_word[15:8], is_last: 1'b0});
      reply_q.push_back('{data: 8'(cnt), is_last: 1'b0});
      for (int unsigned i = 0; i < cnt; i++) begin
        reply_q.push_back('{data: store[i], is_last: (i + 1 == cnt)});
      end
    end
  endtask

  task automatic predict_rx_byte(input logic [7:0] b);
    case (phase)
      HUNT_LO: begin
        if (b == sync_word[7:0]) phase = WAIT_HI;
      end
      WAIT_HI: begin
        // anything but the high byte, the low byte included, keeps it waiting
        if (b == sync_word[15:8]) phase = WAIT_LEN;
      end
      WAIT_LEN: begin
        frame_len = b;
        rcvd_cnt  = '0;
        if (b == 8'd0) close_frame();
        else phase = RECV_PAYLOAD;
      end
      default: begin
        if (rcvd_cnt < DEPTH) store[rcvd_cnt] = b;
        rcvd_cnt = rcvd_cnt + 8'd1;
        if (rcvd_cnt >= frame_len) close_frame();
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rx_valid_i && !rx_stall_o) predict_rx_byte(rx_byte_i);
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t ns: %s got %02h want %02h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && tx_valid_o && !tx_stall_i) begin
      if (reply_q.size() == 0) begin
        report_mismatch("reply item with nothing expected", tx_byte_o, 8'h00);
      end else begin
        exp_beat = reply_q.pop_front();
        if (tx_byte_o !== exp_beat.data) begin
          report_mismatch("tx_byte", tx_byte_o, exp_beat.data);
        end
        if (tx_last_o !== exp_beat.is_last) begin
          report_mismatch("tx_last", {7'd0, tx_last_o}, {7'd0, exp_beat.is_last});
        end
      end
    end
  end

  // no item moved on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && !rx_stall_o) || (tx_valid_o && !tx_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver stall

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        tx_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        tx_stall_i = 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        tx_stall_i = 1'b1;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        tx_stall_i = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (rx_stall_o);
    if (counted) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] cmd,
                            input logic [7:0] echo_len);
    send_byte(sync_word[7:0]);
    send_byte(sync_word[15:8]);
    send_byte(8'(len));
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) send_byte(cmd);
      else if (i == 1) send_byte(echo_len);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    rx_valid_i = 1'b0;
    while (reply_q.size() != 0) @(negedge clk_i);
    // a frame may still be in its command check cycle
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_sync_word(input logic [15:0] w);
    cfg_valid_i = 1'b1;
    cfg_data_i  = w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sync_word = w;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_zero_length_after_reset();
    // store still holds zeros, so no echo command
    send_frame(0, 8'h00, 8'h00);
  endtask

  task automatic test_echo_and_reuse();
    send_frame(2, ECHO_CMD, 8'h03);
    // zero length frame runs the command left in the store
    send_frame(0, 8'h00, 8'h00);
  endtask

  task automatic test_wrong_high_sync();
    send_byte(sync_word[7:0]);
    send_byte(sync_word[7:0]);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(sync_word[15:8]);
    send_byte(8'd1);
    send_byte(8'h07);
    // unknown command, and the stale echo length stays untouched
    send_frame(0, 8'h00, 8'h00);
  endtask

  task automatic test_count_saturation();
    // payload[1] + 2 overflows eight bits here
    send_frame(2, ECHO_CMD, 8'hFE);
    send_frame(2, ECHO_CMD, 8'hFF);
  endtask

  task automatic test_backpressure();
    hold_len = 150;
    send_frame(3, ECHO_CMD, 8'd40);
    send_frame(2, ECHO_CMD, 8'd3);
    send_frame(1, 8'h55, 8'h00);
  endtask

  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned goal;
    int unsigned r;
    int unsigned len;
    logic [7:0]  cmd;
    logic [7:0]  echo_len;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if (r < 15) begin
          // broken start: low sync then junk, the frame below resends the low byte
          send_byte(sync_word[7:0]);
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (r < 10) len = 0;
        else if (r < 18) len = $urandom_range(DEPTH + 1, DEPTH + 8);
        else len = $urandom_range(1, 6);
        cmd = ($urandom_range(0, 99) < 65) ? ECHO_CMD : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 70) echo_len = 8'($urandom_range(0, 8));
        else if (r < 80) echo_len = 8'($urandom_range(8'hFE, 8'hFF));
        else echo_len = 8'($urandom_range(0, 255));
        send_frame(len, cmd, echo_len);
      end
    end
  endtask

  task automatic test_sync_settings();
    logic [15:0] settings [5];
    settings = '{16'($urandom_range(0, 65535)), 16'hFFFF, 16'h0000, 16'h5A5A,
                 SYNC_WORD_RST};
    foreach (settings[i]) begin
      wait_idle();
      write_sync_word(settings[i]);
      if (i == 4) idle_en = 1'b0;
      run_random_traffic(PHASE_ITEMS);
    end
  endtask

  initial begin
    sync_word = SYNC_WORD_RST;
    phase     = HUNT_LO;
    frame_len = '0;
    rcvd_cnt  = '0;
    foreach (store[i]) store[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_zero_length_after_reset();
    test_echo_and_reuse();
    test_wrong_high_sync();
    test_count_saturation();
    test_backpressure();
    test_sync_settings();

    rx_valid_i = 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sld_pkg.sv
rtl/sld_ctrl.sv
rtl/sld_dp.sv
rtl/sync_length_deframer_with_echo.sv
test/tb_sync_length_deframer_with_echo.sv
